FILE: rtl/core/mpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_pkg: shared types, constants and arithmetic helpers
// Fixed-point saturation and clamp functions, memory request structs and the
// sequencer state types of the multichannel pid controller.
// ----------------------------------------------------------------------------
package mpf_pkg;

  localparam int CHANNELS  = 8;
  localparam int CH_W      = 3;
  localparam int COEF_NUM  = 4;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;
  localparam int COEF_FRAC = 24;
  localparam int RATE_FRAC = 16;

  localparam logic [CH_W:0] CH_COUNT = CHANNELS[CH_W:0];

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [15:0] LOOP_TIME_RST = 16'd1;
  localparam logic [16:0] LOOP_RATE_RST = 17'd65536;
  localparam logic [30:0] ILIM_RST      = 31'd655;
  localparam logic [30:0] OLIM_RST      = 31'd65536;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    COEF_P,
    COEF_I,
    COEF_D,
    COEF_F
  } coef_sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_TIME = 0,
    CFG_LOOP_RATE = 1,
    CFG_ILIM      = 2,
    CFG_OLIM      = 3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_SUM
  } seq_state_t;

  typedef enum logic [2:0] {
    MS_KP,
    MS_KI,
    MS_KD,
    MS_KF,
    MS_IT,
    MS_DT,
    MS_FT,
    MS_LAST
  } mul_step_t;

  typedef struct packed {
    logic [15:0] loop_time;
    logic [16:0] loop_rate;
    logic [30:0] ilim;
    logic [30:0] olim;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic signed [31:0] kf;
  } coef_row_t;

  typedef struct packed {
    logic signed [31:0] integ;
    logic signed [31:0] last_sp;
    logic signed [31:0] last_ms;
  } chan_state_t;

  typedef struct packed {
    logic            re;
    logic [CH_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic               we;
    logic [CH_W-1:0]    addr;
    coef_sel_t          sel;
    logic signed [31:0] data;
  } coef_wr_t;

  typedef struct packed {
    logic            we;
    logic [CH_W-1:0] addr;
    chan_state_t     data;
  } st_wr_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32w(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x[65:31] != {35{x[65]}}) begin
      r = x[65] ? SAT_MIN : SAT_MAX;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // saturated difference a - b
  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [31:0] r;
    d = 33'(a) - 33'(b);
    if (d[32] != d[31]) begin
      r = d[32] ? SAT_MIN : SAT_MAX;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

  // symmetric clamp to +-lim
  function automatic logic signed [31:0] clamp_sym(input logic signed [65:0] x,
                                                   input logic [30:0] lim);
    logic signed [65:0] l;
    logic signed [65:0] nl;
    logic signed [31:0] r;
    l  = $signed({35'b0, lim});
    nl = -l;
    if (x > l) begin
      r = l[31:0];
    end else if (x < nl) begin
      r = nl[31:0];
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mpf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_in_if: input item channel
// Valid/ready channel carrying load and step items.
// ----------------------------------------------------------------------------
interface mpf_in_if import mpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [CH_W-1:0]    channel;
  logic [1:0]         coef_select;
  logic signed [31:0] coef_value;
  logic signed [31:0] setpoint;
  logic signed [31:0] measurement;

  modport source (
    output valid, opcode, channel, coef_select, coef_value, setpoint, measurement,
    input  ready
  );

  modport sink (
    input  valid, opcode, channel, coef_select, coef_value, setpoint, measurement,
    output ready
  );
endinterface

FILE: rtl/core/mpf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_out_if: result channel
// Valid/ready channel carrying the terms and drive of one control step.
// ----------------------------------------------------------------------------
interface mpf_out_if import mpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    out_channel;
  logic signed [31:0] p_term;
  logic signed [31:0] i_term;
  logic signed [31:0] d_term;
  logic signed [31:0] f_term;
  logic signed [31:0] drive;
  logic               clamped;

  modport source (
    output valid, out_channel, p_term, i_term, d_term, f_term, drive, clamped,
    input  ready
  );

  modport sink (
    input  valid, out_channel, p_term, i_term, d_term, f_term, drive, clamped,
    output ready
  );
endinterface

FILE: rtl/core/mpf_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mpf_cfg_if import mpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

FILE: rtl/core/mpf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_cfg_regs: configuration register file
// Holds loop time, loop rate and the integral and output limits.
// ----------------------------------------------------------------------------
module mpf_cfg_regs import mpf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mpf_cfg_if.sink cfg_wr,
  output cfg_t cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.index)
        CFG_LOOP_TIME: cfg_nxt.loop_time = cfg_wr.data[15:0];
        CFG_LOOP_RATE: cfg_nxt.loop_rate = cfg_wr.data[16:0];
        CFG_ILIM:      cfg_nxt.ilim      = cfg_wr.data[30:0];
        CFG_OLIM:      cfg_nxt.olim      = cfg_wr.data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loop_time <= LOOP_TIME_RST;
      cfg_r.loop_rate <= LOOP_RATE_RST;
      cfg_r.ilim      <= ILIM_RST;
      cfg_r.olim      <= OLIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/mpf_coef_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_coef_mem: coefficient memory
// One row of four coefficients per channel, written one lane at a time and
// read as a whole row through an output register; unwritten lanes read zero.
// ----------------------------------------------------------------------------
module mpf_coef_mem import mpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  coef_wr_t  wr,
  input  mem_rd_t   rd,
  output coef_row_t rd_row
);

  coef_row_t                            mem [CHANNELS];
  logic [CHANNELS-1:0][COEF_NUM-1:0]    vld_r;
  coef_row_t                            data_r;
  logic [COEF_NUM-1:0]                  rvld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      unique case (wr.sel)
        COEF_P: mem[wr.addr].kp <= wr.data;
        COEF_I: mem[wr.addr].ki <= wr.data;
        COEF_D: mem[wr.addr].kd <= wr.data;
        COEF_F: mem[wr.addr].kf <= wr.data;
        default: ;
      endcase
    end
    if (rd.re) begin
      data_r <= mem[rd.addr];
      rvld_r <= vld_r[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr.addr][wr.sel] <= 1'b1;
    end
  end

  always_comb begin
    rd_row.kp = rvld_r[COEF_P] ? data_r.kp : '0;
    rd_row.ki = rvld_r[COEF_I] ? data_r.ki : '0;
    rd_row.kd = rvld_r[COEF_D] ? data_r.kd : '0;
    rd_row.kf = rvld_r[COEF_F] ? data_r.kf : '0;
  end

endmodule

FILE: rtl/core/mpf_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_state_mem: per-channel loop state memory
// Integrator, last setpoint and last measurement of each channel, with a
// registered read; a channel never written reads as zero.
// ----------------------------------------------------------------------------
module mpf_state_mem import mpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  st_wr_t      wr,
  input  mem_rd_t     rd,
  output chan_state_t rd_state
);

  chan_state_t         mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  chan_state_t         data_r;
  logic                rvld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      data_r <= mem[rd.addr];
      rvld_r <= vld_r[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.we) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_state = rvld_r ? data_r : '0;

endmodule

FILE: rtl/core/mpf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_ctrl: step sequencer and shared multiplier datapath
// Takes items, drives the memories, runs the seven products of a step through
// one registered 33x33 multiplier and launches the result transaction.
// ----------------------------------------------------------------------------
module mpf_ctrl import mpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  mpf_in_if.sink      in_ch,
  mpf_out_if.source   out_res,
  output mem_rd_t     rd,
  output coef_wr_t    coef_wr,
  output st_wr_t      st_wr,
  input  coef_row_t   coef,
  input  chan_state_t chs
);

  seq_state_t state_r;
  seq_state_t state_nxt;
  mul_step_t  step_r;
  mul_step_t  step_nxt;

  logic in_acc;
  logic ch_ok;
  logic is_step;
  logic is_load;
  logic out_free;
  logic sum_ld;

  logic [CH_W-1:0]    ch_r;
  logic signed [31:0] sp_r;
  logic signed [31:0] ms_r;
  logic signed [31:0] dm;
  logic signed [31:0] e_r;
  logic signed [31:0] ds_r;
  logic signed [32:0] ndm_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_r;

  logic signed [31:0] p_r;
  logic signed [31:0] ti_r;
  logic signed [31:0] td_r;
  logic signed [31:0] tf_r;
  logic signed [31:0] i_r;
  logic signed [31:0] d_r;
  logic signed [31:0] f_r;
  logic signed [33:0] pi_r;
  logic signed [33:0] pid_r;
  logic signed [33:0] sum;
  logic signed [31:0] olim32;
  logic               sum_hi;
  logic               sum_lo;

  logic               out_valid_r;
  logic [CH_W-1:0]    out_ch_r;
  logic signed [31:0] out_p_r;
  logic signed [31:0] out_i_r;
  logic signed [31:0] out_d_r;
  logic signed [31:0] out_f_r;
  logic signed [31:0] out_drv_r;
  logic               out_clamp_r;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign ch_ok    = {1'b0, in_ch.channel} < CH_COUNT;
  assign is_step  = in_ch.opcode == OP_STEP;
  assign is_load  = in_ch.opcode == OP_LOAD;
  assign out_free = !out_valid_r || out_res.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && ch_ok && is_step) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        state_nxt = S_MUL;
        step_nxt  = MS_KP;
      end
      S_MUL: begin
        if (step_r == MS_LAST) begin
          state_nxt = S_SUM;
        end else begin
          step_nxt = mul_step_t'(step_r + 3'd1);
        end
      end
      S_SUM: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready     = state_r == S_IDLE;
    rd.re           = in_acc && ch_ok && is_step;
    rd.addr         = in_ch.channel;
    coef_wr.we      = in_acc && ch_ok && is_load;
    coef_wr.addr    = in_ch.channel;
    coef_wr.sel     = coef_sel_t'(in_ch.coef_select);
    coef_wr.data    = in_ch.coef_value;
    sum_ld          = (state_r == S_SUM) && out_free;
    st_wr.we        = sum_ld;
    st_wr.addr      = ch_r;
    st_wr.data      = '{integ: i_r, last_sp: sp_r, last_ms: ms_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= MS_KP;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // multiplier operand select
  always_comb begin
    case (step_r)
      MS_KP:   begin mul_a = 33'(coef.kp); mul_b = 33'(e_r);  end
      MS_KI:   begin mul_a = 33'(coef.ki); mul_b = 33'(e_r);  end
      MS_KD:   begin mul_a = 33'(coef.kd); mul_b = ndm_r;     end
      MS_KF:   begin mul_a = 33'(coef.kf); mul_b = 33'(ds_r); end
      MS_IT:   begin mul_a = 33'(ti_r); mul_b = $signed({17'b0, cfg.loop_time}); end
      MS_DT:   begin mul_a = 33'(td_r); mul_b = $signed({16'b0, cfg.loop_rate}); end
      MS_FT:   begin mul_a = 33'(tf_r); mul_b = $signed({16'b0, cfg.loop_rate}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign dm     = sat_diff(ms_r, chs.last_ms);
  assign olim32 = $signed({1'b0, cfg.olim});
  assign sum    = pid_r + 34'(f_r);
  assign sum_hi = sum > 34'(olim32);
  assign sum_lo = sum < -34'(olim32);

  always_ff @(posedge clk) begin
    if (rd.re) begin
      ch_r <= in_ch.channel;
      sp_r <= in_ch.setpoint;
      ms_r <= in_ch.measurement;
    end
    if (state_r == S_DIFF) begin
      e_r   <= sat_diff(sp_r, ms_r);
      ds_r  <= sat_diff(sp_r, chs.last_sp);
      ndm_r <= -$signed({dm[31], dm});
    end
    if (state_r == S_MUL) begin
      prod_r <= mul_a * mul_b;
      // each slot finishes the product issued in the slot before
      case (step_r)
        MS_KI: p_r  <= sat32w(prod_r >>> COEF_FRAC);
        MS_KD: ti_r <= sat32w(prod_r >>> COEF_FRAC);
        MS_KF: td_r <= sat32w(prod_r >>> COEF_FRAC);
        MS_IT: tf_r <= sat32w(prod_r >>> COEF_FRAC);
        MS_DT: i_r  <= clamp_sym(66'(chs.integ) + prod_r, cfg.ilim);
        MS_FT: begin
          d_r  <= sat32w(prod_r >>> RATE_FRAC);
          pi_r <= 34'(p_r) + 34'(i_r);
        end
        MS_LAST: begin
          f_r   <= sat32w(prod_r >>> RATE_FRAC);
          pid_r <= pi_r + 34'(d_r);
        end
        default: ;
      endcase
    end
    if (sum_ld) begin
      out_ch_r    <= ch_r;
      out_p_r     <= p_r;
      out_i_r     <= i_r;
      out_d_r     <= d_r;
      out_f_r     <= f_r;
      out_drv_r   <= sum_hi ? olim32 : (sum_lo ? -olim32 : sum[31:0]);
      out_clamp_r <= sum_hi || sum_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sum_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.out_channel = out_ch_r;
  assign out_res.p_term      = out_p_r;
  assign out_res.i_term      = out_i_r;
  assign out_res.d_term      = out_d_r;
  assign out_res.f_term      = out_f_r;
  assign out_res.drive       = out_drv_r;
  assign out_res.clamped     = out_clamp_r;

`ifndef SYNTH
  a_wb_launch: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.we |=> out_valid_r)
    else $error("state write-back without result transaction");

  a_rd_flow: assert property (@(posedge clk) disable iff (!rst_n)
    rd.re |=> state_r == S_DIFF)
    else $error("memory read not followed by difference stage");

  a_drive_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drv_r <= olim32) && (out_drv_r >= -olim32))
    else $error("drive outside output limit");

  a_clamp_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clamp_r |-> (out_drv_r == olim32) || (out_drv_r == -olim32))
    else $error("clamped drive not at limit");

  a_i_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_i_r <= $signed({1'b0, cfg.ilim}))
                 && (out_i_r >= -$signed({1'b0, cfg.ilim})))
    else $error("integral term outside integral limit");
`endif

endmodule

FILE: rtl/core/multichannel_pid_feedforward.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_pid_feedforward: time-multiplexed pid controller with feedforward
// Eight channels share one datapath. A load transaction writes one Q8.24
// coefficient of a channel. A step transaction passes a memory read, one
// difference stage, eight slots of the single shared 33x33 multiplier that
// forms the seven products in turn, and one sum and clamp stage that waits
// while the previous result is not taken; the result is offered in the
// cycle after that stage and the next item can be accepted while it waits.
// The coefficients and the per-channel loop state sit in two small memories
// whose entries read as zero until written, so the block takes items
// straight out of reset. The user must write configuration through its own
// channel only while no step is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module multichannel_pid_feedforward import mpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mpf_in_if.sink    in_ch,
  mpf_out_if.source out_res,
  mpf_cfg_if.sink   cfg_wr
);

  cfg_t        cfg;
  mem_rd_t     rd;
  coef_wr_t    coef_wr;
  st_wr_t      st_wr;
  coef_row_t   coef;
  chan_state_t chs;

  mpf_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  mpf_coef_mem u_coef_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (coef_wr),
    .rd     (rd),
    .rd_row (coef)
  );

  mpf_state_mem u_state_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (st_wr),
    .rd       (rd),
    .rd_state (chs)
  );

  mpf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_res (out_res),
    .rd      (rd),
    .coef_wr (coef_wr),
    .st_wr   (st_wr),
    .coef    (coef),
    .chs     (chs)
  );

endmodule
